/* src/swfr_pkg.sv */
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types and constants for the sync word frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int CMD_W   = 16;
  localparam int LEN_W   = 11;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 16;
  localparam int SYNC_W  = 32;
  localparam int CFG_W   = 32;
  localparam int TDATA_W = 80;

  // Header limit and register reset values
  localparam logic [15:0]      PAYLOAD_LIMIT   = 16'd1024;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 11'd1024;

  // Accepted command id ranges
  localparam logic [15:0] ID_LO_MIN = 16'h0001;
  localparam logic [15:0] ID_LO_MAX = 16'h0008;
  localparam logic [15:0] ID_HI_MIN = 16'h8001;
  localparam logic [15:0] ID_HI_MAX = 16'h8008;

  // Window holds eight bytes once full
  localparam logic [3:0] FILL_FULL = 4'd8;

  // Queue between front and back; depth must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic REG_SYNC_WORD   = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_HDR     = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  // One classified word handed from front to back.
  // For OP_HDR, data carries the header byte sum.
  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [CMD_W-1:0] cmd;
    logic [LEN_W-1:0] len;
  } qent_t;

endpackage

/* src/swfr_front.sv */
// ----------------------------------------------------------------------------
// swfr_front
// Accepts received bytes, hunts for headers and classifies each byte.
// ----------------------------------------------------------------------------
module swfr_front
  import swfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  output logic              push_valid,
  output qent_t             push_ent,
  input  logic              push_ready
);

  logic [SYNC_W-1:0] sync_word;
  logic [LEN_W-1:0]  max_payload;

  phase_t           phase, phase_next;
  logic [63:0]      window, window_next;
  logic [3:0]       fill, fill_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] bytes_seen, bytes_seen_next;

  logic             accept;
  logic [63:0]      win_shift;
  logic [3:0]       fill_inc;
  logic [15:0]      hdr_id;
  logic [15:0]      hdr_len;
  logic             id_ok;
  logic             len_ok;
  logic             hdr_hit;
  logic [7:0]       hdr_sum;
  logic [LEN_W-1:0] seen_inc;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word   <= '0;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_WORD:   sync_word   <= cfg_data[SYNC_W-1:0];
        REG_MAX_PAYLOAD: max_payload <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Header candidate once this byte enters the window
  always_comb begin
    win_shift = {in_byte, window[63:8]};
    fill_inc  = (fill >= FILL_FULL) ? FILL_FULL : fill + 4'd1;
    hdr_id    = win_shift[47:32];
    hdr_len   = win_shift[63:48];
    id_ok     = (hdr_id >= ID_LO_MIN && hdr_id <= ID_LO_MAX) ||
                (hdr_id >= ID_HI_MIN && hdr_id <= ID_HI_MAX);
    len_ok    = (hdr_len <= {5'd0, max_payload}) && (hdr_len <= PAYLOAD_LIMIT);
    hdr_hit   = (fill_inc >= FILL_FULL) && (win_shift[31:0] == sync_word) &&
                id_ok && len_ok;
    hdr_sum   = '0;
    for (int i = 0; i < 8; i++) begin
      hdr_sum = hdr_sum + win_shift[8*i +: 8];
    end
    seen_inc = bytes_seen + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      window       <= '0;
      fill         <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
    end else begin
      phase        <= phase_next;
      window       <= window_next;
      fill         <= fill_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    window_next       = window;
    fill_next         = fill;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    push_valid        = 1'b0;
    push_ent.op       = OP_PAYLOAD;
    push_ent.data     = in_byte;
    push_ent.idx      = bytes_seen[IDX_W-1:0];
    push_ent.cmd      = hdr_id;
    push_ent.len      = hdr_len[LEN_W-1:0];
    if (accept) begin
      unique case (phase)
        PH_PAYLOAD: begin
          push_valid      = 1'b1;
          bytes_seen_next = seen_inc;
          if (seen_inc >= frame_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          push_valid  = 1'b1;
          push_ent.op = OP_CHECK;
          phase_next  = PH_HUNT;
          window_next = '0;
          fill_next   = '0;
        end
        default: begin
          // Slide the window; on a valid header hand it to the back end
          phase_next  = PH_HUNT;
          window_next = win_shift;
          fill_next   = fill_inc;
          if (hdr_hit) begin
            push_valid        = 1'b1;
            push_ent.op       = OP_HDR;
            push_ent.data     = hdr_sum;
            frame_length_next = hdr_len[LEN_W-1:0];
            bytes_seen_next   = '0;
            phase_next        = (hdr_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            window_next       = '0;
            fill_next         = '0;
          end
        end
      endcase
    end
  end

endmodule

/* src/swfr_queue.sv */
// ----------------------------------------------------------------------------
// swfr_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module swfr_queue
  import swfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  qent_t push_ent,
  output logic  push_ready,
  output logic  pop_valid,
  output qent_t pop_ent,
  input  logic  pop
);

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_ent    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/swfr_back.sv */
// ----------------------------------------------------------------------------
// swfr_back
// Executes classified words: checksum, frame counts and the output register.
// ----------------------------------------------------------------------------
module swfr_back
  import swfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  qent_t             q_ent,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [CMD_W-1:0]  out_cmd,
  output logic [7:0]        out_data,
  output logic [IDX_W-1:0]  out_idx,
  output logic [LEN_W-1:0]  out_len,
  output logic [CNT_W-1:0]  out_good,
  output logic [CNT_W-1:0]  out_bad,
  output logic              out_last
);

  logic [CMD_W-1:0] frame_command;
  logic [LEN_W-1:0] frame_length;
  logic [7:0]       running_sum;
  logic [CNT_W-1:0] good_count;
  logic [CNT_W-1:0] bad_count;
  logic             sum_match;

  // Header words carry no result and drain even while the output is held
  assign q_pop     = q_valid && (q_ent.op == OP_HDR || !out_valid || out_ready);
  assign sum_match = (q_ent.data == running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      frame_command <= '0;
      frame_length  <= '0;
      running_sum   <= '0;
      good_count    <= '0;
      bad_count     <= '0;
    end else begin
      if (q_pop && q_ent.op != OP_HDR) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_ent.op)
          OP_HDR: begin
            frame_command <= q_ent.cmd;
            frame_length  <= q_ent.len;
            running_sum   <= q_ent.data;
          end
          OP_PAYLOAD: begin
            running_sum <= running_sum + q_ent.data;
          end
          OP_CHECK: begin
            if (sum_match) begin
              good_count <= good_count + 1'b1;
            end else begin
              bad_count <= bad_count + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result payload; counts shown already updated on end results
  always_ff @(posedge clk) begin
    if (q_pop && q_ent.op != OP_HDR) begin
      out_cmd  <= frame_command;
      out_data <= q_ent.data;
      out_len  <= frame_length;
      if (q_ent.op == OP_PAYLOAD) begin
        out_kind <= KIND_PAYLOAD;
        out_idx  <= q_ent.idx;
        out_good <= good_count;
        out_bad  <= bad_count;
        out_last <= 1'b0;
      end else begin
        out_kind <= sum_match ? KIND_GOOD : KIND_BAD;
        out_idx  <= '0;
        out_good <= sum_match ? good_count + 1'b1 : good_count;
        out_bad  <= sum_match ? bad_count : bad_count + 1'b1;
        out_last <= 1'b1;
      end
    end
  end

endmodule

/* src/sync_word_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_receiver_unit
// Sync word deframer with an 8-bit additive checksum and frame counters.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                      carries
//  --------  ---------  ---------------------------  -----------------------------
//  s_*       in         s_tvalid s_tready s_tdata    one received byte per word
//  m_*       out        m_tvalid m_tready m_tdata    payload bytes and end results
//                       m_tuser m_tlast
//  cfg_*     in         cfg_we cfg_index cfg_data    sync word, max payload length
//
//  Throughput is one byte per clock while the queue has room; the front end
//  classifies a byte in the cycle it is accepted and the back end executes one
//  queued word per clock into the output register while m_* is not stalled.
//  Reset (rst, synchronous) empties the queue and the output register and
//  returns to hunting with an empty window and zero frame counts.
//  A stall on m_tready fills the four-word queue, then drops s_tready;
//  header words drain from the queue even while a result is held.
//
module sync_word_frame_receiver_unit
  import swfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,    // 0 sync_word, 1 max_payload
  input  logic [CFG_W-1:0]   cfg_data,
  // byte input
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,      // [7:0] rx_byte
  // result output
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,      // [15:0] command_id, [23:16] data_byte,
                                           // [33:24] byte_index,
                                           // [44:34] payload_length,
                                           // [60:45] good_frames,
                                           // [76:61] bad_frames, [79:77] zero
  output logic [1:0]         m_tuser,      // [1:0] kind
  output logic               m_tlast
);

  qent_t            push_ent;
  qent_t            pop_ent;
  logic             push_valid;
  logic             push_ready;
  logic             pop_valid;
  logic             pop;
  kind_t            out_kind;
  logic [CMD_W-1:0] out_cmd;
  logic [7:0]       out_data;
  logic [IDX_W-1:0] out_idx;
  logic [LEN_W-1:0] out_len;
  logic [CNT_W-1:0] out_good;
  logic [CNT_W-1:0] out_bad;

  // Front: window hunt, header match, payload/check sequencing
  swfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_ready   (s_tready),
    .push_valid (push_valid),
    .push_ent   (push_ent),
    .push_ready (push_ready)
  );

  // Decouple classification from execution
  swfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ent   (push_ent),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ent    (pop_ent),
    .pop        (pop)
  );

  // Back: checksum, counters, output register
  swfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ent     (pop_ent),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_cmd   (out_cmd),
    .out_data  (out_data),
    .out_idx   (out_idx),
    .out_len   (out_len),
    .out_good  (out_good),
    .out_bad   (out_bad),
    .out_last  (m_tlast)
  );

  // Pack result fields, command id in the lowest bits
  assign m_tdata = {3'b000, out_bad, out_good, out_len, out_idx, out_data, out_cmd};
  assign m_tuser = out_kind;

endmodule

/* src/swfr_checker.sv */
// ----------------------------------------------------------------------------
// swfr_checker
// Port-level checks of the receiver's result stream.
// ----------------------------------------------------------------------------
module swfr_checker
  import swfr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [1:0]         m_tuser,
  input logic               m_tlast
);

  // Hold a result until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // End results and only end results carry tlast
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != KIND_PAYLOAD)))
    else $error("tlast does not match result kind");

  // Payload index stays below the declared length
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PAYLOAD |-> {1'b0, m_tdata[33:24]} < m_tdata[44:34])
    else $error("payload index beyond declared length");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sync_word_frame_receiver_unit swfr_checker u_swfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks sync_word_frame_receiver_unit against a cycle-free model of the
// deframer. Random frames with good and bad checksums, broken headers and
// noise are pushed through the byte stream. Both sides idle at random. Every
// result word is compared with the model's prediction, in order.
// ----------------------------------------------------------------------------
module testbench;
  import swfr_pkg::*;

  // One expected or observed result word, unpacked into its fields
  typedef struct packed {
    kind_t            kind;
    logic [CMD_W-1:0] cmd;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] good;
    logic [CNT_W-1:0] bad;
    logic             last;
  } frame_result_t;

  // Model of the deframer plus the queue of result words still owed by the
  // block. Feed it every accepted byte, in order, and every accepted result.
  class frame_scoreboard;
    logic [SYNC_W-1:0] sync_word;
    logic [LEN_W-1:0]  max_len;
    logic [63:0]       window;   // oldest byte in the low eight bits
    logic [3:0]        fill;
    phase_t            ph;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  flen;
    logic [LEN_W-1:0]  seen;
    logic [7:0]        sum;
    logic [CNT_W-1:0]  good_n;
    logic [CNT_W-1:0]  bad_n;
    frame_result_t     owed_q[$];
    int unsigned       errors;
    int unsigned       reported;

    function new();
      sync_word = '0;
      max_len   = MAX_PAYLOAD_RST;
      window    = '0;
      fill      = '0;
      ph        = PH_HUNT;
      cmd       = '0;
      flen      = '0;
      seen      = '0;
      sum       = '0;
      good_n    = '0;
      bad_n     = '0;
      errors    = 0;
      reported  = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_SYNC_WORD) begin
        sync_word = value[SYNC_W-1:0];
      end else begin
        max_len = value[LEN_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance the model by one accepted byte and queue the word it causes
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      logic [15:0]   id;
      logic [15:0]   hlen;
      logic [15:0]   lim;
      logic [7:0]    hsum;
      int            i;
      r = '0;
      case (ph)
        PH_PAYLOAD: begin
          r.kind = KIND_PAYLOAD;
          r.cmd  = cmd;
          r.data = b;
          r.idx  = seen[IDX_W-1:0];
          r.len  = flen;
          r.good = good_n;
          r.bad  = bad_n;
          r.last = 1'b0;
          sum  = sum + b;
          seen = seen + 1'b1;
          if (seen >= flen) ph = PH_CHECK;
          owed_q.push_back(r);
        end
        PH_CHECK: begin
          if (b == sum) begin
            good_n = good_n + 1'b1;
            r.kind = KIND_GOOD;
          end else begin
            bad_n  = bad_n + 1'b1;
            r.kind = KIND_BAD;
          end
          r.cmd  = cmd;
          r.data = b;
          r.idx  = '0;
          r.len  = flen;
          r.good = good_n;
          r.bad  = bad_n;
          r.last = 1'b1;
          owed_q.push_back(r);
          // resume hunting with the next byte, no rescan
          ph     = PH_HUNT;
          window = '0;
          fill   = '0;
        end
        default: begin
          ph     = PH_HUNT;
          window = {b, window[63:8]};
          if (fill < FILL_FULL) fill = fill + 1'b1;
          if (fill >= FILL_FULL) begin
            id   = window[47:32];
            hlen = window[63:48];
            lim  = (16'(max_len) < PAYLOAD_LIMIT) ? 16'(max_len) : PAYLOAD_LIMIT;
            if (window[31:0] == sync_word && hlen <= lim &&
                ((id >= ID_LO_MIN && id <= ID_LO_MAX) ||
                 (id >= ID_HI_MIN && id <= ID_HI_MAX))) begin
              hsum = '0;
              for (i = 0; i < 8; i++) hsum = hsum + window[8*i +: 8];
              cmd    = id;
              flen   = hlen[LEN_W-1:0];
              seen   = '0;
              sum    = hsum;
              ph     = (flen == '0) ? PH_CHECK : PH_PAYLOAD;
              window = '0;
              fill   = '0;
            end
          end
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest one owed
    function void check_result(logic [1:0] tuser, logic [TDATA_W-1:0] d, logic tl);
      frame_result_t e;
      frame_result_t a;
      a.kind = kind_t'(tuser);
      a.cmd  = d[15:0];
      a.data = d[23:16];
      a.idx  = d[33:24];
      a.len  = d[44:34];
      a.good = d[60:45];
      a.bad  = d[76:61];
      a.last = tl;
      if (owed_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          $write("unexpected word: kind %0d cmd %h data %h idx %0d",
                 a.kind, a.cmd, a.data, a.idx);
          $display(" len %0d good %0d bad %0d last %b",
                   a.len, a.good, a.bad, a.last);
        end
        reported++;
        return;
      end
      e = owed_q.pop_front();
      if (a.kind !== e.kind || a.cmd !== e.cmd || a.data !== e.data || a.idx !== e.idx ||
          a.len !== e.len || a.good !== e.good || a.bad !== e.bad || a.last !== e.last) begin
        errors++;
        if (reported < 10) begin
          $write("mismatch at %0t: expected kind %0d cmd %h data %h idx %0d",
                 $realtime, e.kind, e.cmd, e.data, e.idx);
          $display(" len %0d good %0d bad %0d last %b",
                   e.len, e.good, e.bad, e.last);
          $write("                   actual kind %0d cmd %h data %h idx %0d",
                 a.kind, a.cmd, a.data, a.idx);
          $display(" len %0d good %0d bad %0d last %b",
                   a.len, a.good, a.bad, a.last);
        end
        reported++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;     // [7:0] rx_byte
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;     // [15:0] command_id, [23:16] data_byte,
                                   // [33:24] byte_index, [44:34] payload_length,
                                   // [60:45] good_frames, [76:61] bad_frames
  logic [1:0]         m_tuser;     // [1:0] kind
  logic               m_tlast;

  frame_scoreboard   sb;
  bit                calm;         // sender: no gaps for the current frame
  logic              rx_calm;      // receiver copy of calm, set once per frame
  bit                hold_go;      // start the long receiver hold-off
  logic              hold_out;     // receiver held off while high
  logic [SYNC_W-1:0] cur_sync;
  logic [LEN_W-1:0]  cur_max;
  int unsigned       items_sent;

  sync_word_frame_receiver_unit uut (
    .clk, .rst,
    .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte, optionally after a gap, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    items_sent++;
  endtask

  // Send a frame: header, payload, checksum. A nonzero cut sends only that
  // many leading bytes, which lets a header go out with no frame behind it.
  task automatic send_frame(input logic [SYNC_W-1:0] flag, input logic [15:0] id,
                            input int unsigned len, input int unsigned cut,
                            input bit sum_ok);
    logic [63:0] hdr;
    logic [7:0]  total;
    logic [7:0]  b;
    int unsigned n;
    int unsigned i;
    hdr   = {len[15:0], id, flag};
    n     = (cut != 0) ? cut : len + 9;
    total = '0;
    for (i = 0; i < n; i++) begin
      if (i < 8) begin
        b = hdr[8*i +: 8];
      end else if (i < len + 8) begin
        b = 8'($urandom);
      end else begin
        // corrupt the checksum by a nonzero pattern
        b = sum_ok ? total : total ^ 8'($urandom_range(1, 255));
      end
      total = total + b;
      send_byte(b);
    end
  endtask

  // Mostly well-formed frames; the rest are broken headers and noise
  task automatic random_frame();
    int unsigned r;
    int unsigned len;
    int unsigned lim;
    logic [15:0] id;
    logic [15:0] bad;
    lim  = 32'((16'(cur_max) < PAYLOAD_LIMIT) ? 16'(cur_max) : PAYLOAD_LIMIT);
    calm = ($urandom_range(0, 7) == 0);
    rx_calm <= calm;
    id = $urandom_range(0, 1) ? 16'($urandom_range(ID_LO_MIN, ID_LO_MAX))
                              : 16'($urandom_range(ID_HI_MIN, ID_HI_MAX));
    case ($urandom_range(0, 4))
      0:       bad = ID_LO_MIN - 16'd1;
      1:       bad = ID_LO_MAX + 16'd1;
      2:       bad = ID_HI_MIN - 16'd1;
      3:       bad = ID_HI_MAX + 16'd1;
      default: bad = 16'hFFFF ^ 16'($urandom_range(0, 16'h7FF0));
    endcase
    // keep payloads short; hit the limit itself only when it is small
    r = $urandom_range(0, 9);
    if (r == 0) len = 0;
    else if (r == 1 && lim <= 64) len = lim;
    else len = $urandom_range(0, (lim < 20) ? lim : 20);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_frame(cur_sync, id, len, 0, 1'b1);
    end else if (r < 70) begin
      send_frame(cur_sync, id, len, 0, 1'b0);
    end else if (r < 76) begin
      send_frame(cur_sync, bad, len, 8, 1'b1);
    end else if (r < 82) begin
      // declared length just above the limit, sometimes far above
      send_frame(cur_sync, id,
                 lim + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65534 - lim) : 0),
                 8, 1'b1);
    end else if (r < 87) begin
      // one sync bit flipped: the whole frame must be hunted over
      send_frame(cur_sync ^ (32'h1 << $urandom_range(0, 31)), id, len, 0,
                 1'($urandom_range(0, 1)));
    end else if (r < 93) begin
      send_frame(cur_sync, id, len, $urandom_range(1, 7), 1'b1);
    end else begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
    end
  endtask

  // Drop valid and let the block drain, including header words with no result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic configure(input logic [SYNC_W-1:0] sw, input logic [LEN_W-1:0] mp);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_WORD;
    cfg_data  <= CFG_W'(sw);
    @(posedge clk);
    sb.write_reg(REG_SYNC_WORD, CFG_W'(sw));
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_data  <= CFG_W'(mp);
    @(posedge clk);
    sb.write_reg(REG_MAX_PAYLOAD, CFG_W'(mp));
    cfg_we   <= 1'b0;
    cur_sync  = sw;
    cur_max   = mp;
  endtask

  task automatic run_phase(input logic [SYNC_W-1:0] sw, input logic [LEN_W-1:0] mp,
                           input int unsigned budget, input bit with_long);
    int unsigned start;
    configure(sw, mp);
    if (with_long) begin
      // largest frame, sent back to back while the receiver holds off
      calm    = 1'b1;
      rx_calm <= 1'b1;
      hold_go = 1'b1;
      send_frame(cur_sync, ID_HI_MAX, 32'(PAYLOAD_LIMIT), 0, 1'b1);
    end
    start = items_sent;
    while (items_sent - start < budget) random_frame();
  endtask

  // Result side: check accepted words, then pick tready for the next cycle
  initial begin : result_sink
    int unsigned stall_left;
    bit          rdy;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
      if (hold_out) begin
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (rx_calm) begin
        rdy = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        rdy        = (stall_left == 0);
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  // Long hold-off on the result side, counted here so the sender keeps going
  initial begin : receiver_hold
    hold_out <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin : stimulus
    sb         = new();
    calm       = 1'b0;
    hold_go    = 1'b0;
    items_sent = 0;
    cur_sync   = '0;
    cur_max    = MAX_PAYLOAD_RST;
    rst       <= 1'b1;
    rx_calm   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SYNC_WORD;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: header right after reset fills the window
    // exactly; empty payload at the lowest id, then one byte at the highest
    // id with a bad checksum, then a header with an id just out of range.
    send_frame(cur_sync, ID_LO_MIN, 0, 0, 1'b1);
    send_frame(cur_sync, ID_HI_MAX, 1, 0, 1'b0);
    send_frame(cur_sync, ID_LO_MAX + 16'd1, 0, 8, 1'b1);

    // Random phases over a spread of settings, extremes first
    run_phase(32'hFFFF_FFFF, 11'd0, 100, 1'b0);
    run_phase(32'($urandom), MAX_PAYLOAD_RST, 40, 1'b1);
    run_phase(32'h0000_0000, 11'($urandom_range(1, 12)), 80, 1'b0);
    run_phase(32'($urandom), 11'($urandom_range(13, 64)), 80, 1'b0);
    run_phase(32'($urandom), MAX_PAYLOAD_RST, 80, 1'b0);

    settle();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Safety net: far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sync_word_frame_receiver_unit.f */
src/swfr_pkg.sv
src/swfr_front.sv
src/swfr_queue.sv
src/swfr_back.sv
src/sync_word_frame_receiver_unit.sv
src/swfr_checker.sv
test/testbench.sv
